### hdl/thct_pkg.sv
// ----------------------------------------------------------------------------
// thct_pkg
// Shared types, codes and constants for the type hash-consing table.
// ----------------------------------------------------------------------------
package thct_pkg;

  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam int          FIRST_ID  = 8;

  localparam logic [2:0] KIND_ARRAY  = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_REF    = 3'd2;
  localparam logic [2:0] KIND_VECTOR = 3'd3;
  localparam logic [2:0] KIND_MATRIX = 3'd4;
  localparam logic [2:0] KIND_DICT   = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LOAD     = 2'd1;
  localparam logic [1:0] STATUS_NO_IDS   = 2'd2;

  // Outcome of one lookup, chosen by the controller.
  typedef enum logic [2:0] {
    RES_NULL,
    RES_HIT,
    RES_NEW,
    RES_FULL,
    RES_NOIDS
  } result_t;

  typedef struct packed {
    logic    load_input;
    logic    mix;
    logic    mix_second;
    logic    probe_start;
    logic    probe_advance;
    logic    clear_write;
    logic    insert;
    logic    out_load;
    result_t result;
  } cmd_t;

  typedef struct packed {
    logic kind_unused;
    logic kind_dict;
    logic slot_valid;
    logic slot_match;
    logic load_full;
    logic ids_out;
    logic sweep_last;
    logic probe_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] kind_hash_seed(input logic [2:0] kind);
    logic [31:0] tag;
    unique case (kind)
      KIND_ARRAY:  tag = 32'h41;
      KIND_SET:    tag = 32'h53;
      KIND_REF:    tag = 32'h52;
      KIND_VECTOR: tag = 32'h56;
      KIND_MATRIX: tag = 32'h4d;
      KIND_DICT:   tag = 32'h44;
      default:     tag = 32'h0;
    endcase
    return tag;
  endfunction

endpackage

### hdl/thct_datapath.sv
// ----------------------------------------------------------------------------
// thct_datapath
// Hash unit, slot store, probe index, counters and result register.
// ----------------------------------------------------------------------------
module thct_datapath
  import thct_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output dp_status_t  st,
  input  logic [2:0]  kind_code,
  input  logic [15:0] first_child_id,
  input  logic [15:0] second_child_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] type_id,
  output logic        created,
  output logic [1:0]  status
);

  localparam int IDX_BITS = $clog2(SLOT_COUNT);
  localparam int OCC_BITS = $clog2(SLOT_COUNT + 1);
  localparam int LOAD_MAX = (SLOT_COUNT * 7 + 9) / 10;

  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic [15:0]        first_child;
    logic [15:0]        second_child;
    logic [ID_BITS-1:0] id;
  } entry_t;

  entry_t slot_mem [SLOT_COUNT];
  entry_t rd_entry;
  entry_t wr_entry;
  logic   mem_we;

  logic [2:0]          kind;
  logic [15:0]         first_child;
  logic [15:0]         second_child;
  logic [31:0]         hash_acc;
  logic [31:0]         mix_in;
  logic [31:0]         hash_next;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] idx_next;
  logic [IDX_BITS-1:0] steps;
  logic [OCC_BITS-1:0] occupied;
  logic [ID_BITS:0]    next_id;
  logic [ID_BITS-1:0]  id_sel;
  logic [ID_BITS+15:0] id_ext;

  // One FNV step per cycle: (h ^ v) * prime, kept modulo 2^32.
  assign mix_in    = cmd.mix_second ? (hash_acc ^ {16'b0, second_child})
                                    : (kind_hash_seed(kind) ^ {16'b0, first_child});
  assign hash_next = mix_in * FNV_PRIME;

  // Wrap the probe index at the end of the store.
  assign idx_next = (idx == IDX_BITS'(SLOT_COUNT - 1)) ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      kind         <= kind_code;
      first_child  <= first_child_id;
      second_child <= (kind_code == KIND_DICT) ? second_child_id : 16'b0;
    end
    if (cmd.mix) begin
      hash_acc <= hash_next;
    end
    if (cmd.probe_start) begin
      steps <= '0;
    end else if (cmd.probe_advance) begin
      steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      occupied <= '0;
      next_id  <= (ID_BITS + 1)'(FIRST_ID);
    end else begin
      if (cmd.probe_start) begin
        idx <= hash_next[IDX_BITS-1:0];
      end else if (cmd.probe_advance || cmd.clear_write) begin
        idx <= idx_next;
      end
      if (cmd.insert) begin
        occupied <= occupied + 1'b1;
        next_id  <= next_id + 1'b1;
      end
    end
  end

  // Slot store: one write and one registered read, both at idx.
  assign mem_we = cmd.clear_write || cmd.insert;

  always_comb begin
    wr_entry = '0;
    if (cmd.insert) begin
      wr_entry.valid        = 1'b1;
      wr_entry.kind         = kind;
      wr_entry.first_child  = first_child;
      wr_entry.second_child = second_child;
      wr_entry.id           = next_id[ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx] <= wr_entry;
    end
    rd_entry <= slot_mem[idx];
  end

  assign st.kind_unused = (kind > KIND_DICT);
  assign st.kind_dict   = (kind == KIND_DICT);
  assign st.slot_valid  = rd_entry.valid;
  assign st.slot_match  = (rd_entry.kind == kind) &&
                          (rd_entry.first_child == first_child) &&
                          (rd_entry.second_child == second_child);
  assign st.load_full   = (occupied >= OCC_BITS'(LOAD_MAX));
  assign st.ids_out     = next_id[ID_BITS];
  assign st.sweep_last  = (idx == IDX_BITS'(SLOT_COUNT - 1));
  assign st.probe_last  = (steps == IDX_BITS'(SLOT_COUNT - 1));
  assign st.out_free    = !out_valid || out_ready;

  // Result register.
  assign id_sel = (cmd.result == RES_HIT) ? rd_entry.id : next_id[ID_BITS-1:0];
  assign id_ext = {16'b0, id_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.result)
        RES_HIT: begin
          type_id <= id_ext[15:0];
          created <= 1'b0;
          status  <= STATUS_OK;
        end
        RES_NEW: begin
          type_id <= id_ext[15:0];
          created <= 1'b1;
          status  <= STATUS_OK;
        end
        RES_FULL: begin
          type_id <= 16'b0;
          created <= 1'b0;
          status  <= STATUS_LOAD;
        end
        RES_NOIDS: begin
          type_id <= 16'b0;
          created <= 1'b0;
          status  <= STATUS_NO_IDS;
        end
        default: begin
          type_id <= 16'b0;
          created <= 1'b0;
          status  <= STATUS_OK;
        end
      endcase
    end
  end

endmodule

### hdl/thct_ctrl.sv
// ----------------------------------------------------------------------------
// thct_ctrl
// Sequencer for clearing, hashing, probing and answering one lookup.
// ----------------------------------------------------------------------------
module thct_ctrl
  import thct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t  state;
  state_t  state_next;
  result_t res_code;
  result_t res_code_next;

  always_comb begin
    cmd           = '0;
    cmd.result    = res_code;
    in_ready      = 1'b0;
    state_next    = state;
    res_code_next = res_code;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (st.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_input = in_valid;
        if (in_valid) begin
          state_next = S_HASH1;
        end
      end
      S_HASH1: begin
        if (st.kind_unused) begin
          res_code_next = RES_NULL;
          state_next    = S_FINISH;
        end else if (st.kind_dict) begin
          cmd.mix    = 1'b1;
          state_next = S_HASH2;
        end else begin
          cmd.mix         = 1'b1;
          cmd.probe_start = 1'b1;
          state_next      = S_READ;
        end
      end
      S_HASH2: begin
        cmd.mix         = 1'b1;
        cmd.mix_second  = 1'b1;
        cmd.probe_start = 1'b1;
        state_next      = S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!st.slot_valid) begin
          if (st.load_full) begin
            res_code_next = RES_FULL;
          end else if (st.ids_out) begin
            res_code_next = RES_NOIDS;
          end else begin
            res_code_next = RES_NEW;
          end
          state_next = S_FINISH;
        end else if (st.slot_match) begin
          res_code_next = RES_HIT;
          state_next    = S_FINISH;
        end else if (st.probe_last) begin
          res_code_next = RES_FULL;
          state_next    = S_FINISH;
        end else begin
          cmd.probe_advance = 1'b1;
          state_next        = S_READ;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.insert   = (res_code == RES_NEW);
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= RES_NULL;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

### hdl/type_hash_cons_table.sv
// ----------------------------------------------------------------------------
// type_hash_cons_table
// Hash-consing table that maps compound type descriptors to canonical ids.
// ----------------------------------------------------------------------------
// Each input transfer names a kind (array, set, ref, vector, matrix, dict) and
// one or two child ids; the block answers with exactly one result transfer
// holding the canonical id, a created flag and a status code. The kind tag and
// children are hashed FNV-style, one multiply per cycle, and the slot store is
// probed linearly from (hash mod SLOT_COUNT) through a single-port memory with
// a registered read, so each probed slot takes a read state and a check state.
// An accepted item passes through a hash state (two for dict), then a read and
// check per probe, then a finish state that loads the result once the output
// register is free; unused kind codes go from the first hash state straight
// to finish. One item is in flight at a time. The result sits in an output
// register, and the next item is taken once the current one has been handed
// to that register. After reset the block runs a clearing pass over every
// slot of the store with in_ready low. New ids start at 8; inserts stop at
// 70% occupancy (status 1) or when ids reach 2^ID_BITS (status 2), while
// lookups that hit keep answering. SLOT_COUNT must be a power of two.
// ----------------------------------------------------------------------------
module type_hash_cons_table
  import thct_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind_code,
  input  logic [15:0] first_child_id,
  input  logic [15:0] second_child_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] type_id,
  output logic        created,
  output logic [1:0]  status
);

  cmd_t       cmd;
  dp_status_t st;

  // Sequence clear, hash, probe and answer.
  thct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold the slot store, hash, counters and the result register.
  thct_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .kind_code       (kind_code),
    .first_child_id  (first_child_id),
    .second_child_id (second_child_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .type_id         (type_id),
    .created         (created),
    .status          (status)
  );

endmodule

### hdl/thct_check.sv
// ----------------------------------------------------------------------------
// thct_check
// Port-level checks for the type hash-consing table, bound to the top level.
// ----------------------------------------------------------------------------
module thct_check
  import thct_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] type_id,
  input logic        created,
  input logic [1:0]  status
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(type_id) &&
                                $stable(created) && $stable(status))
    else $error("result changed while stalled");

  // Failed lookups carry no id and create nothing.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> (type_id == 16'b0) && !created)
    else $error("failed lookup carries an id");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK) || (status == STATUS_LOAD) ||
                  (status == STATUS_NO_IDS))
    else $error("undefined status code");

  // Input is not taken in the cycle after a transfer in: one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind type_hash_cons_table thct_check u_thct_check (.*);
